// ----- src/lobu_pkg.sv -----
package lobu_pkg;

  localparam int ORDER_SLOTS     = 1024;
  localparam int LEVELS_PER_SIDE = 64;
  localparam int INSTRUMENTS     = 16;

  localparam int LEVEL_COUNT = INSTRUMENTS * 2 * LEVELS_PER_SIDE;
  localparam int SLOT_AW     = $clog2(ORDER_SLOTS);
  localparam int LVL_AW      = $clog2(LEVEL_COUNT);
  localparam int BOOK_W      = (INSTRUMENTS > 1) ? $clog2(INSTRUMENTS) : 1;

  // scan counter covers the slot table or both sides of one book
  localparam int SCAN_N = (ORDER_SLOTS > 2 * LEVELS_PER_SIDE) ? ORDER_SLOTS
                                                              : 2 * LEVELS_PER_SIDE;
  localparam int SCAN_W = $clog2(SCAN_N + 1);

  // clearing pass after reset
  localparam int CLR_N = (ORDER_SLOTS > LEVEL_COUNT) ? ORDER_SLOTS : LEVEL_COUNT;
  localparam int CLR_W = $clog2(CLR_N + 1);

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_EXECUTE = 3'd1;
  localparam logic [2:0] OP_CANCEL  = 3'd2;
  localparam logic [2:0] OP_DELETE  = 3'd3;
  localparam logic [2:0] OP_REPLACE = 3'd4;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_UNKNOWN = 2'd1;
  localparam logic [1:0] STS_CLAMPED = 2'd2;
  localparam logic [1:0] STS_FULL    = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SLOT_SCAN,
    S_LVL_SCAN,
    S_DECIDE,
    S_LVL_REM,
    S_LVL_SCAN2,
    S_LVL_ADD,
    S_SLOT_FREE,
    S_SLOT_WR,
    S_BEST_SCAN,
    S_DONE
  } lobu_state_t;

  typedef struct packed {
    logic              valid;
    logic [63:0]       key;
    logic [31:0]       shares;
    logic [31:0]       price;
    logic [BOOK_W-1:0] book;
    logic              side;
  } slot_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] price;
    logic [63:0] total;
    logic [31:0] orders;
  } level_t;

  typedef struct packed {
    logic key_hit;
    logic nkey_hit;
    logic free;
  } slot_hit_t;

  typedef struct packed {
    logic hit;
    logic old_hit;
    logic free;
  } lvl_hit_t;

  typedef logic [BOOK_W-1:0] book_map_t [16];

  function automatic book_map_t build_book_map();
    book_map_t m;
    for (int i = 0; i < 16; i++) begin
      m[i] = BOOK_W'(i % INSTRUMENTS);
    end
    return m;
  endfunction

  localparam book_map_t BOOK_MAP = build_book_map();

endpackage

// ----- src/lobu_if.sv -----
interface lobu_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [63:0] order_key;
  logic [63:0] new_order_key;
  logic [3:0]  instrument;
  logic        buy_side;
  logic [31:0] quantity;
  logic [31:0] limit_price;
  logic [47:0] event_time;

  modport source (output valid, operation, order_key, new_order_key, instrument,
                  buy_side, quantity, limit_price, event_time, input ready);
  modport sink   (input valid, operation, order_key, new_order_key, instrument,
                  buy_side, quantity, limit_price, event_time, output ready);
endinterface

interface lobu_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  book_instrument;
  logic        bid_present;
  logic [31:0] best_bid_price;
  logic [63:0] best_bid_shares;
  logic        ask_present;
  logic [31:0] best_ask_price;
  logic [63:0] best_ask_shares;
  logic [47:0] last_update;

  modport source (output valid, status, book_instrument, bid_present, best_bid_price,
                  best_bid_shares, ask_present, best_ask_price, best_ask_shares,
                  last_update, input ready);
  modport sink   (input valid, status, book_instrument, bid_present, best_bid_price,
                  best_bid_shares, ask_present, best_ask_price, best_ask_shares,
                  last_update, output ready);
endinterface

// ----- src/lobu_slot_table.sv -----
module lobu_slot_table (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [lobu_pkg::SLOT_AW-1:0] wr_addr,
  input  lobu_pkg::slot_t              wr_data,
  input  logic [lobu_pkg::SLOT_AW-1:0] rd_addr,
  output lobu_pkg::slot_t              rd_data,
  input  logic [63:0]                  key,
  input  logic [63:0]                  nkey,
  output lobu_pkg::slot_hit_t          hit
);

  lobu_pkg::slot_t mem [lobu_pkg::ORDER_SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // compare on the registered entry
  assign hit.key_hit  = rd_data.valid && (rd_data.key == key);
  assign hit.nkey_hit = rd_data.valid && (rd_data.key == nkey);
  assign hit.free     = !rd_data.valid;

endmodule

// ----- src/lobu_level_table.sv -----
module lobu_level_table (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [lobu_pkg::LVL_AW-1:0] wr_addr,
  input  lobu_pkg::level_t            wr_data,
  input  logic [lobu_pkg::LVL_AW-1:0] rd_addr,
  output lobu_pkg::level_t            rd_data,
  input  logic [31:0]                 tgt_price,
  input  logic [31:0]                 old_price,
  output lobu_pkg::lvl_hit_t          hit
);

  lobu_pkg::level_t mem [lobu_pkg::LEVEL_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign hit.hit     = rd_data.valid && (rd_data.price == tgt_price);
  assign hit.old_hit = rd_data.valid && (rd_data.price == old_price);
  assign hit.free    = !rd_data.valid;

endmodule

// ----- src/limit_order_book_update.sv -----
// Limit order book update.
// order_in carries one order message per transaction (add, execute, cancel,
// delete, replace); book_out carries one result per message: status, the
// touched book's best bid and best ask with their shares, and its last
// update time. Both channels use valid/ready; a transaction moves on a
// rising edge with both high.
// Flow: a message is worked on alone. The slot table is swept once per add,
// execute, cancel, delete or replace message, through its single read
// port; then, unless a non-add message names an unknown order, the 64
// levels of one side (twice for a replace); then both sides of the book
// for the best prices, plus a handful of single-state steps. An unused
// operation goes straight to the best-price sweep.
// order_in.ready is high only while the sequencer waits for a message.
// Reset: rst is synchronous. A clearing pass over max(ORDER_SLOTS,
// LEVEL_COUNT) entries then marks every slot and level free; no message
// is taken meanwhile. Book timestamps reset to zero.
// Stall: the result sits in an output register; the next message can be
// taken and worked while it waits, and a finished result waits for the
// register to empty before the sequencer returns for more input.
module limit_order_book_update (
  input  logic      clk,
  input  logic      rst,
  lobu_in_if.sink   order_in,
  lobu_out_if.source book_out
);

  lobu_pkg::lobu_state_t state, state_next;

  // message registers
  logic [2:0]                  op;
  logic [63:0]                 key;
  logic [63:0]                 nkey;
  logic [lobu_pkg::BOOK_W-1:0] book;
  logic                        side;
  logic [31:0]                 qty;
  logic [31:0]                 price;
  logic [47:0]                 evt;
  logic [1:0]                  status;

  // slot sweep results
  logic                         s_found, f_found, n_found;
  logic [lobu_pkg::SLOT_AW-1:0] s_idx, f_idx, n_idx;
  logic [31:0]                  o_shares, o_price;
  logic [lobu_pkg::BOOK_W-1:0]  o_book;
  logic                         o_side;
  logic [31:0]                  left;
  logic [31:0]                  rem_qty;
  logic                         rem_full;

  // level sweep results
  logic                        h_found, fr_found, ol_found;
  logic [lobu_pkg::LVL_AW-1:0] h_idx, fr_idx, ol_idx;
  lobu_pkg::level_t            h_data, ol_data;

  // best level trackers
  logic        bid_have, ask_have;
  logic [31:0] bid_price, ask_price;
  logic [63:0] bid_sh, ask_sh;

  logic [47:0] book_stamp [lobu_pkg::INSTRUMENTS];

  // sweep control
  logic [lobu_pkg::SCAN_W-1:0] scan_cnt, scan_len, pend_off;
  logic                        pend, issue, scan_done, scan_state, scan_enter;
  logic [lobu_pkg::CLR_W-1:0]  clr_cnt;
  logic [lobu_pkg::LVL_AW-1:0] lvl_base;
  logic                        side_sel;

  // memory ports
  logic                         slot_we;
  logic [lobu_pkg::SLOT_AW-1:0] slot_waddr;
  lobu_pkg::slot_t              slot_wdata, slot_rd;
  lobu_pkg::slot_hit_t          shit;
  logic                         lvl_we;
  logic [lobu_pkg::LVL_AW-1:0]  lvl_waddr;
  lobu_pkg::level_t             lvl_wdata, lvl_rd, rem_data, add_data, add_base;
  lobu_pkg::lvl_hit_t           lhit;
  logic                         stamp_we;
  logic [64:0]                  add_sum;

  logic in_fire, out_load, out_valid, add_ok, rep_ok, is_bid;

  assign order_in.ready = (state == lobu_pkg::S_IDLE);
  assign in_fire        = order_in.valid && order_in.ready;
  assign out_load       = (state == lobu_pkg::S_DONE) && (!out_valid || book_out.ready);

  assign add_ok = (s_found || f_found) && (h_found || fr_found);
  assign rep_ok = h_found || fr_found || (ol_found && (ol_data.orders <= 32'd1));

  // sweep bookkeeping: one read issued per cycle, its data arrives in the next cycle
  assign scan_state = (state == lobu_pkg::S_SLOT_SCAN) || (state == lobu_pkg::S_LVL_SCAN) ||
                      (state == lobu_pkg::S_LVL_SCAN2) || (state == lobu_pkg::S_BEST_SCAN);
  assign scan_enter = (state_next != state) &&
                      ((state_next == lobu_pkg::S_SLOT_SCAN) ||
                       (state_next == lobu_pkg::S_LVL_SCAN) ||
                       (state_next == lobu_pkg::S_LVL_SCAN2) ||
                       (state_next == lobu_pkg::S_BEST_SCAN));

  always_comb begin
    case (state)
      lobu_pkg::S_SLOT_SCAN: scan_len = lobu_pkg::SCAN_W'(lobu_pkg::ORDER_SLOTS);
      lobu_pkg::S_BEST_SCAN: scan_len = lobu_pkg::SCAN_W'(2 * lobu_pkg::LEVELS_PER_SIDE);
      default:               scan_len = lobu_pkg::SCAN_W'(lobu_pkg::LEVELS_PER_SIDE);
    endcase
  end

  assign issue     = scan_state && (scan_cnt < scan_len);
  assign scan_done = (scan_cnt == scan_len) && !pend;
  assign is_bid    = (pend_off >= lobu_pkg::SCAN_W'(lobu_pkg::LEVELS_PER_SIDE));

  // best sweep covers ask then bid side of the book
  assign side_sel = (state == lobu_pkg::S_BEST_SCAN) ? 1'b0 : side;
  assign lvl_base = lobu_pkg::LVL_AW'(lobu_pkg::LVL_AW'({book, side_sel}) *
                                      lobu_pkg::LVL_AW'(lobu_pkg::LEVELS_PER_SIDE));

  lobu_slot_table u_slots (
    .clk     (clk),
    .wr_en   (slot_we),
    .wr_addr (slot_waddr),
    .wr_data (slot_wdata),
    .rd_addr (lobu_pkg::SLOT_AW'(scan_cnt)),
    .rd_data (slot_rd),
    .key     (key),
    .nkey    (nkey),
    .hit     (shit)
  );

  lobu_level_table u_levels (
    .clk       (clk),
    .wr_en     (lvl_we),
    .wr_addr   (lvl_waddr),
    .wr_data   (lvl_wdata),
    .rd_addr   (lvl_base + lobu_pkg::LVL_AW'(scan_cnt)),
    .rd_data   (lvl_rd),
    .tgt_price (price),
    .old_price (o_price),
    .hit       (lhit)
  );

  // level updates: removal with floor at zero, addition with saturation
  always_comb begin
    rem_data       = ol_data;
    rem_data.total = ({32'd0, rem_qty} > ol_data.total) ? 64'd0
                                                        : ol_data.total - {32'd0, rem_qty};
    rem_data.orders = (rem_full && (ol_data.orders != 32'd0)) ? ol_data.orders - 32'd1
                                                              : ol_data.orders;
    rem_data.valid  = (rem_data.orders != 32'd0);

    if (h_found) begin
      add_base = h_data;
    end else begin
      add_base.valid  = 1'b0;
      add_base.price  = price;
      add_base.total  = 64'd0;
      add_base.orders = 32'd0;
    end
    add_sum         = {1'b0, add_base.total} + {33'd0, qty};
    add_data.valid  = 1'b1;
    add_data.price  = add_base.price;
    add_data.total  = add_sum[64] ? {64{1'b1}} : add_sum[63:0];
    add_data.orders = (add_base.orders == {32{1'b1}}) ? add_base.orders
                                                      : add_base.orders + 32'd1;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lobu_pkg::S_CLEAR:
        if (clr_cnt == lobu_pkg::CLR_W'(lobu_pkg::CLR_N - 1)) begin
          state_next = lobu_pkg::S_IDLE;
        end
      lobu_pkg::S_IDLE:
        if (in_fire) begin
          state_next = (order_in.operation <= lobu_pkg::OP_REPLACE) ? lobu_pkg::S_SLOT_SCAN
                                                                    : lobu_pkg::S_BEST_SCAN;
        end
      lobu_pkg::S_SLOT_SCAN:
        if (scan_done) begin
          state_next = ((op == lobu_pkg::OP_ADD) || s_found) ? lobu_pkg::S_LVL_SCAN
                                                             : lobu_pkg::S_BEST_SCAN;
        end
      lobu_pkg::S_LVL_SCAN:
        if (scan_done) begin
          state_next = lobu_pkg::S_DECIDE;
        end
      lobu_pkg::S_DECIDE:
        case (op)
          lobu_pkg::OP_ADD:
            state_next = add_ok ? lobu_pkg::S_LVL_ADD : lobu_pkg::S_BEST_SCAN;
          lobu_pkg::OP_EXECUTE, lobu_pkg::OP_CANCEL, lobu_pkg::OP_DELETE:
            state_next = lobu_pkg::S_LVL_REM;
          lobu_pkg::OP_REPLACE:
            state_next = rep_ok ? lobu_pkg::S_LVL_REM : lobu_pkg::S_BEST_SCAN;
          default:
            state_next = lobu_pkg::S_BEST_SCAN;
        endcase
      lobu_pkg::S_LVL_REM:
        state_next = (op == lobu_pkg::OP_REPLACE) ? lobu_pkg::S_LVL_SCAN2 : lobu_pkg::S_SLOT_WR;
      lobu_pkg::S_LVL_SCAN2:
        if (scan_done) begin
          state_next = (h_found || fr_found) ? lobu_pkg::S_LVL_ADD : lobu_pkg::S_SLOT_FREE;
        end
      lobu_pkg::S_LVL_ADD:
        state_next = (op == lobu_pkg::OP_REPLACE) ? lobu_pkg::S_SLOT_FREE : lobu_pkg::S_SLOT_WR;
      lobu_pkg::S_SLOT_FREE:
        state_next = lobu_pkg::S_SLOT_WR;
      lobu_pkg::S_SLOT_WR:
        state_next = lobu_pkg::S_BEST_SCAN;
      lobu_pkg::S_BEST_SCAN:
        if (scan_done) begin
          state_next = lobu_pkg::S_DONE;
        end
      lobu_pkg::S_DONE:
        if (out_load) begin
          state_next = lobu_pkg::S_IDLE;
        end
      default:
        state_next = lobu_pkg::S_IDLE;
    endcase
  end

  // memory write controls
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = s_idx;
    slot_wdata = '0;
    lvl_we     = 1'b0;
    lvl_waddr  = ol_idx;
    lvl_wdata  = rem_data;
    stamp_we   = 1'b0;
    case (state)
      lobu_pkg::S_CLEAR: begin
        slot_we    = (clr_cnt < lobu_pkg::CLR_W'(lobu_pkg::ORDER_SLOTS));
        slot_waddr = lobu_pkg::SLOT_AW'(clr_cnt);
        lvl_we     = (clr_cnt < lobu_pkg::CLR_W'(lobu_pkg::LEVEL_COUNT));
        lvl_waddr  = lobu_pkg::LVL_AW'(clr_cnt);
        lvl_wdata  = '0;
      end
      lobu_pkg::S_LVL_REM: begin
        lvl_we = ol_found;
      end
      lobu_pkg::S_LVL_ADD: begin
        lvl_we    = 1'b1;
        lvl_waddr = h_found ? h_idx : fr_idx;
        lvl_wdata = add_data;
      end
      lobu_pkg::S_SLOT_FREE: begin
        slot_we = 1'b1;
      end
      lobu_pkg::S_SLOT_WR: begin
        slot_we  = 1'b1;
        stamp_we = 1'b1;
        slot_wdata.book = book;
        slot_wdata.side = side;
        case (op)
          lobu_pkg::OP_ADD: begin
            slot_waddr        = s_found ? s_idx : f_idx;
            slot_wdata.valid  = 1'b1;
            slot_wdata.key    = key;
            slot_wdata.shares = qty;
            slot_wdata.price  = price;
          end
          lobu_pkg::OP_EXECUTE, lobu_pkg::OP_CANCEL: begin
            slot_wdata.valid  = (left != 32'd0);
            slot_wdata.key    = key;
            slot_wdata.shares = left;
            slot_wdata.price  = o_price;
          end
          lobu_pkg::OP_REPLACE: begin
            slot_waddr        = n_found ? n_idx : s_idx;
            slot_wdata.valid  = 1'b1;
            slot_wdata.key    = nkey;
            slot_wdata.shares = qty;
            slot_wdata.price  = price;
          end
          default: begin
            slot_wdata.valid = 1'b0;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lobu_pkg::S_CLEAR;
      clr_cnt   <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < lobu_pkg::INSTRUMENTS; i++) begin
        book_stamp[i] <= 48'd0;
      end
    end else begin
      state <= state_next;
      if (state == lobu_pkg::S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (scan_enter) begin
        pend <= 1'b0;
      end else begin
        pend <= issue;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (book_out.ready) begin
        out_valid <= 1'b0;
      end
      if (stamp_we) begin
        book_stamp[book] <= evt;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op     <= order_in.operation;
      key    <= order_in.order_key;
      nkey   <= order_in.new_order_key;
      book   <= lobu_pkg::BOOK_MAP[order_in.instrument];
      side   <= order_in.buy_side;
      qty    <= order_in.quantity;
      price  <= order_in.limit_price;
      evt    <= order_in.event_time;
      status <= lobu_pkg::STS_OK;
    end

    if (scan_enter) begin
      scan_cnt <= '0;
      h_found  <= 1'b0;
      fr_found <= 1'b0;
      ol_found <= 1'b0;
      bid_have <= 1'b0;
      ask_have <= 1'b0;
      bid_price <= 32'd0;
      ask_price <= 32'd0;
      bid_sh    <= 64'd0;
      ask_sh    <= 64'd0;
      if (state_next == lobu_pkg::S_SLOT_SCAN) begin
        s_found <= 1'b0;
        f_found <= 1'b0;
        n_found <= 1'b0;
      end
    end else if (issue) begin
      scan_cnt <= scan_cnt + 1'b1;
    end
    pend_off <= scan_cnt;

    if (pend && (state == lobu_pkg::S_SLOT_SCAN)) begin
      if (shit.key_hit && !s_found) begin
        s_found  <= 1'b1;
        s_idx    <= lobu_pkg::SLOT_AW'(pend_off);
        o_shares <= slot_rd.shares;
        o_price  <= slot_rd.price;
        o_book   <= slot_rd.book;
        o_side   <= slot_rd.side;
      end
      if (shit.free && !f_found) begin
        f_found <= 1'b1;
        f_idx   <= lobu_pkg::SLOT_AW'(pend_off);
      end
      if (shit.nkey_hit && !n_found) begin
        n_found <= 1'b1;
        n_idx   <= lobu_pkg::SLOT_AW'(pend_off);
      end
    end

    if (pend && ((state == lobu_pkg::S_LVL_SCAN) || (state == lobu_pkg::S_LVL_SCAN2))) begin
      if (lhit.hit && !h_found) begin
        h_found <= 1'b1;
        h_idx   <= lvl_base + lobu_pkg::LVL_AW'(pend_off);
        h_data  <= lvl_rd;
      end
      if (lhit.free && !fr_found) begin
        fr_found <= 1'b1;
        fr_idx   <= lvl_base + lobu_pkg::LVL_AW'(pend_off);
      end
      if (lhit.old_hit && !ol_found) begin
        ol_found <= 1'b1;
        ol_idx   <= lvl_base + lobu_pkg::LVL_AW'(pend_off);
        ol_data  <= lvl_rd;
      end
    end

    // strict compare keeps the first level found on a tie
    if (pend && (state == lobu_pkg::S_BEST_SCAN) && lvl_rd.valid) begin
      if (is_bid) begin
        if (!bid_have || (lvl_rd.price > bid_price)) begin
          bid_have  <= 1'b1;
          bid_price <= lvl_rd.price;
          bid_sh    <= lvl_rd.total;
        end
      end else begin
        if (!ask_have || (lvl_rd.price < ask_price)) begin
          ask_have  <= 1'b1;
          ask_price <= lvl_rd.price;
          ask_sh    <= lvl_rd.total;
        end
      end
    end

    // known order: its stored book and side take over
    if ((state == lobu_pkg::S_SLOT_SCAN) && scan_done && (op != lobu_pkg::OP_ADD)) begin
      if (s_found) begin
        book <= o_book;
        side <= o_side;
      end else begin
        status <= lobu_pkg::STS_UNKNOWN;
      end
    end

    if (state == lobu_pkg::S_DECIDE) begin
      case (op)
        lobu_pkg::OP_ADD: begin
          if (!add_ok) begin
            status <= lobu_pkg::STS_FULL;
          end
        end
        lobu_pkg::OP_EXECUTE, lobu_pkg::OP_CANCEL: begin
          if (qty > o_shares) begin
            left     <= 32'd0;
            rem_qty  <= o_shares;
            rem_full <= 1'b1;
            status   <= lobu_pkg::STS_CLAMPED;
          end else begin
            left     <= o_shares - qty;
            rem_qty  <= qty;
            rem_full <= (o_shares == qty);
          end
        end
        lobu_pkg::OP_DELETE: begin
          left     <= 32'd0;
          rem_qty  <= o_shares;
          rem_full <= 1'b1;
        end
        lobu_pkg::OP_REPLACE: begin
          left     <= 32'd0;
          rem_qty  <= o_shares;
          rem_full <= 1'b1;
          if (!rep_ok) begin
            status <= lobu_pkg::STS_FULL;
          end
        end
        default: begin
        end
      endcase
    end

    if (out_load) begin
      book_out.status          <= status;
      book_out.book_instrument <= 4'(book);
      book_out.bid_present     <= bid_have;
      book_out.best_bid_price  <= bid_price;
      book_out.best_bid_shares <= bid_sh;
      book_out.ask_present     <= ask_have;
      book_out.best_ask_price  <= ask_price;
      book_out.best_ask_shares <= ask_sh;
      book_out.last_update     <= book_stamp[book];
    end
  end

  assign book_out.valid = out_valid;

`ifndef SYNTHESIS
  a_lvl_set_only_in_update: assert property (@(posedge clk) disable iff (rst)
    (lvl_we && lvl_wdata.valid) |->
      (state == lobu_pkg::S_LVL_ADD) || (state == lobu_pkg::S_LVL_REM))
    else $error("level marked valid outside an update step");

  a_add_has_target: assert property (@(posedge clk) disable iff (rst)
    (state == lobu_pkg::S_LVL_ADD) |-> (h_found || fr_found))
    else $error("level add without a target level");

  a_unknown_not_add: assert property (@(posedge clk) disable iff (rst)
    (out_load && (status == lobu_pkg::STS_UNKNOWN)) |-> (op != lobu_pkg::OP_ADD))
    else $error("unknown reference reported for an add");

  a_no_input_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == lobu_pkg::S_CLEAR) |=> !$past(in_fire))
    else $error("message taken during clearing pass");
`endif

endmodule

// ----- tb/sv/limit_order_book_scoreboard.sv -----
module limit_order_book_scoreboard (
  input  logic clk,
  input  logic rst,
  lobu_in_if   order_in,
  lobu_out_if  book_out,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  book;
    logic        bid_present;
    logic [31:0] bid_price;
    logic [63:0] bid_shares;
    logic        ask_present;
    logic [31:0] ask_price;
    logic [63:0] ask_shares;
    logic [47:0] stamp;
  } book_view_t;

  // shadow order table and price levels
  logic        ord_live  [lobu_pkg::ORDER_SLOTS];
  logic [63:0] ord_key   [lobu_pkg::ORDER_SLOTS];
  logic [31:0] ord_qty   [lobu_pkg::ORDER_SLOTS];
  logic [31:0] ord_px    [lobu_pkg::ORDER_SLOTS];
  int          ord_book  [lobu_pkg::ORDER_SLOTS];
  logic        ord_side  [lobu_pkg::ORDER_SLOTS];
  logic        lvl_live  [lobu_pkg::LEVEL_COUNT];
  logic [31:0] lvl_px    [lobu_pkg::LEVEL_COUNT];
  logic [63:0] lvl_total [lobu_pkg::LEVEL_COUNT];
  logic [31:0] lvl_cnt   [lobu_pkg::LEVEL_COUNT];
  logic [47:0] stamp     [lobu_pkg::INSTRUMENTS];

  book_view_t expected_views[$];

  function automatic int lookup_order(logic [63:0] k);
    for (int i = 0; i < lobu_pkg::ORDER_SLOTS; i++)
      if (ord_live[i] && ord_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int free_order();
    for (int i = 0; i < lobu_pkg::ORDER_SLOTS; i++)
      if (!ord_live[i]) return i;
    return -1;
  endfunction

  function automatic int lookup_level(int b, logic sd, logic [31:0] px);
    int base;
    base = (b * 2 + sd) * lobu_pkg::LEVELS_PER_SIDE;
    for (int j = 0; j < lobu_pkg::LEVELS_PER_SIDE; j++)
      if (lvl_live[base + j] && lvl_px[base + j] == px) return base + j;
    return -1;
  endfunction

  function automatic int free_level(int b, logic sd);
    int base;
    base = (b * 2 + sd) * lobu_pkg::LEVELS_PER_SIDE;
    for (int j = 0; j < lobu_pkg::LEVELS_PER_SIDE; j++)
      if (!lvl_live[base + j]) return base + j;
    return -1;
  endfunction

  function automatic void level_credit(int lv, logic [31:0] px, logic [31:0] q);
    logic [64:0] sum;
    if (!lvl_live[lv]) begin
      lvl_live[lv]  = 1'b1;
      lvl_px[lv]    = px;
      lvl_total[lv] = '0;
      lvl_cnt[lv]   = '0;
    end
    sum = {1'b0, lvl_total[lv]} + 65'(q);
    lvl_total[lv] = sum[64] ? '1 : sum[63:0];
    if (lvl_cnt[lv] != '1) lvl_cnt[lv]++;
  endfunction

  function automatic void level_debit(int b, logic sd, logic [31:0] px, logic [31:0] q,
                                      logic whole);
    int lv;
    lv = lookup_level(b, sd, px);
    if (lv < 0) return;
    lvl_total[lv] = (64'(q) > lvl_total[lv]) ? '0 : lvl_total[lv] - 64'(q);
    if (whole && lvl_cnt[lv] > 0) lvl_cnt[lv]--;
    if (lvl_cnt[lv] == 0) lvl_live[lv] = 1'b0;
  endfunction

  function automatic void best_level(int b, logic sd, output logic have,
                                     output logic [31:0] px, output logic [63:0] sh);
    int base;
    base = (b * 2 + sd) * lobu_pkg::LEVELS_PER_SIDE;
    have = 0; px = '0; sh = '0;
    for (int j = 0; j < lobu_pkg::LEVELS_PER_SIDE; j++) begin
      if (!lvl_live[base + j]) continue;
      if (!have || (sd ? lvl_px[base + j] > px : lvl_px[base + j] < px)) begin
        have = 1; px = lvl_px[base + j]; sh = lvl_total[base + j];
      end
    end
  endfunction

  function automatic book_view_t apply_message();
    book_view_t v;
    int s, lv, ol, ts, b;
    logic sd;
    logic [31:0] opx, osh, left;
    logic [2:0] op;
    op = order_in.operation;
    b = order_in.instrument % lobu_pkg::INSTRUMENTS;
    v = '0;
    v.status = lobu_pkg::STS_OK;
    if (op == lobu_pkg::OP_ADD) begin
      s  = lookup_order(order_in.order_key);
      lv = lookup_level(b, order_in.buy_side, order_in.limit_price);
      if (s < 0) s = free_order();
      if (lv < 0) lv = free_level(b, order_in.buy_side);
      if (s < 0 || lv < 0) v.status = lobu_pkg::STS_FULL;
      else begin
        level_credit(lv, order_in.limit_price, order_in.quantity);
        ord_live[s] = 1; ord_key[s] = order_in.order_key;
        ord_qty[s] = order_in.quantity; ord_px[s] = order_in.limit_price;
        ord_book[s] = b; ord_side[s] = order_in.buy_side;
        stamp[b] = order_in.event_time;
      end
    end else if (op inside {lobu_pkg::OP_EXECUTE, lobu_pkg::OP_CANCEL, lobu_pkg::OP_DELETE,
                            lobu_pkg::OP_REPLACE}) begin
      s = lookup_order(order_in.order_key);
      if (s < 0) v.status = lobu_pkg::STS_UNKNOWN;
      else begin
        sd = ord_side[s]; opx = ord_px[s]; osh = ord_qty[s]; b = ord_book[s];
        if (op == lobu_pkg::OP_EXECUTE || op == lobu_pkg::OP_CANCEL) begin
          if (order_in.quantity > osh) begin
            left = '0; v.status = lobu_pkg::STS_CLAMPED;
          end else left = osh - order_in.quantity;
          level_debit(b, sd, opx, osh - left, left == 0);
          if (left == 0) ord_live[s] = 0;
          else ord_qty[s] = left;
          stamp[b] = order_in.event_time;
        end else if (op == lobu_pkg::OP_DELETE) begin
          level_debit(b, sd, opx, osh, 1'b1);
          ord_live[s] = 0;
          stamp[b] = order_in.event_time;
        end else begin
          ol = lookup_level(b, sd, opx);
          if (!(lookup_level(b, sd, order_in.limit_price) >= 0 || free_level(b, sd) >= 0 ||
                (ol >= 0 && lvl_cnt[ol] <= 1))) v.status = lobu_pkg::STS_FULL;
          else begin
            ord_live[s] = 0;
            level_debit(b, sd, opx, osh, 1'b1);
            lv = lookup_level(b, sd, order_in.limit_price);
            if (lv < 0) lv = free_level(b, sd);
            if (lv >= 0) level_credit(lv, order_in.limit_price, order_in.quantity);
            ts = lookup_order(order_in.new_order_key);
            if (ts < 0) ts = s;
            ord_live[ts] = 1; ord_key[ts] = order_in.new_order_key;
            ord_qty[ts] = order_in.quantity; ord_px[ts] = order_in.limit_price;
            ord_book[ts] = b; ord_side[ts] = sd;
            stamp[b] = order_in.event_time;
          end
        end
      end
    end
    v.book = 4'(b);
    best_level(b, 1'b1, v.bid_present, v.bid_price, v.bid_shares);
    best_level(b, 1'b0, v.ask_present, v.ask_price, v.ask_shares);
    v.stamp = stamp[b];
    return v;
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("%0t book_out %s: got %0h, expected %0h", $time, field, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    book_view_t w;
    if (rst) begin
      for (int i = 0; i < lobu_pkg::ORDER_SLOTS; i++) ord_live[i] = 0;
      for (int i = 0; i < lobu_pkg::LEVEL_COUNT; i++) lvl_live[i] = 0;
      for (int i = 0; i < lobu_pkg::INSTRUMENTS; i++) stamp[i] = '0;
      expected_views.delete();
    end else begin
      if (order_in.valid && order_in.ready)
        expected_views.insert(expected_views.size(), apply_message());
      if (book_out.valid && book_out.ready) begin
        if (expected_views.size() == 0) report("unexpected transaction", 0, 0);
        else begin
          w = expected_views.pop_front();
          if (book_out.status !== w.status) report("status", book_out.status, w.status);
          if (book_out.book_instrument !== w.book)
            report("book_instrument", book_out.book_instrument, w.book);
          if (book_out.bid_present !== w.bid_present)
            report("bid_present", book_out.bid_present, w.bid_present);
          if (book_out.best_bid_price !== w.bid_price)
            report("best_bid_price", book_out.best_bid_price, w.bid_price);
          if (book_out.best_bid_shares !== w.bid_shares)
            report("best_bid_shares", book_out.best_bid_shares, w.bid_shares);
          if (book_out.ask_present !== w.ask_present)
            report("ask_present", book_out.ask_present, w.ask_present);
          if (book_out.best_ask_price !== w.ask_price)
            report("best_ask_price", book_out.best_ask_price, w.ask_price);
          if (book_out.best_ask_shares !== w.ask_shares)
            report("best_ask_shares", book_out.best_ask_shares, w.ask_shares);
          if (book_out.last_update !== w.stamp)
            report("last_update", book_out.last_update, w.stamp);
        end
      end
    end
    pending <= expected_views.size();
  end

endmodule

// ----- tb/sv/limit_order_book_update_test.sv -----
module limit_order_book_update_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;

  lobu_in_if  order_in ();
  lobu_out_if book_out ();

  limit_order_book_update dut (
    .clk      (clk),
    .rst      (rst),
    .order_in (order_in),
    .book_out (book_out)
  );

  limit_order_book_scoreboard checker_i (
    .clk        (clk),
    .rst        (rst),
    .order_in   (order_in),
    .book_out   (book_out),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // keys the stimulus believes are resting in the book; only steers hit rate
  logic [63:0] resting_keys[$];
  int          burst_left = 0;
  int          results_seen = 0;

  initial begin
    order_in.valid         = 1'b0;
    order_in.operation     = lobu_pkg::OP_ADD;
    order_in.order_key     = '0;
    order_in.new_order_key = '0;
    order_in.instrument    = '0;
    order_in.buy_side      = 1'b0;
    order_in.quantity      = '0;
    order_in.limit_price   = '0;
    order_in.event_time    = '0;
    book_out.ready         = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [47:0] rand_stamp();
    logic [63:0] r;
    r = rand64();
    return r[47:0];
  endfunction

  function automatic logic rand_side();
    return 1'($urandom_range(0, 1));
  endfunction

  // Offer one message and hold it until the block takes it. Called at a rising
  // edge; returns at the edge where the transaction happened. Ready only moves
  // at rising edges, so its value at the falling edge is what the next rising
  // edge sees.
  task automatic send(logic [2:0] op, logic [63:0] key, logic [63:0] nkey,
                      logic [3:0] instr, logic side, logic [31:0] qty,
                      logic [31:0] px, logic [47:0] ts);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 4);
      if (gap > 0) begin
        order_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    order_in.valid         <= 1'b1;
    order_in.operation     <= op;
    order_in.order_key     <= key;
    order_in.new_order_key <= nkey;
    order_in.instrument    <= instr;
    order_in.buy_side      <= side;
    order_in.quantity      <= qty;
    order_in.limit_price   <= px;
    order_in.event_time    <= ts;
    forever begin
      @(negedge clk);
      if (order_in.ready) break;
    end
    @(posedge clk);
  endtask

  function automatic logic [63:0] pick_resting();
    if (resting_keys.size() == 0) return rand64();
    return resting_keys[$urandom_range(0, resting_keys.size() - 1)];
  endfunction

  function automatic void forget_key(logic [63:0] k);
    foreach (resting_keys[i])
      if (resting_keys[i] == k) begin
        resting_keys.delete(i);
        return;
      end
  endfunction

  function automatic void remember_key(logic [63:0] k);
    resting_keys.insert(resting_keys.size(), k);
  endfunction

  function automatic logic [31:0] pick_qty();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom;
      2:       return 32'hFFFF_FFFF;
      default: return 32'($urandom_range(1, 500));
    endcase
  endfunction

  // One random message: mostly well-formed traffic on resting orders,
  // some unknown keys and unused opcodes as noise.
  task automatic random_message(int add_weight);
    logic [63:0] key, nkey;
    logic [3:0]  instr;
    logic [31:0] px;
    int          roll;
    instr = 4'($urandom_range(0, 15));
    px = ($urandom_range(0, 19) == 0) ? $urandom : 32'(1000 + instr * 50 + $urandom_range(0, 30));
    roll = $urandom_range(0, 99);
    if (roll < add_weight || resting_keys.size() == 0) begin
      key = ($urandom_range(0, 9) == 0) ? pick_resting() : rand64();
      send(lobu_pkg::OP_ADD, key, rand64(), instr, rand_side(), pick_qty(), px, rand_stamp());
      if ($urandom_range(0, 9) != 0 || resting_keys.size() == 0) begin
        forget_key(key);
        remember_key(key);
      end
    end else if (roll < 95) begin
      key = ($urandom_range(0, 14) == 0) ? rand64() : pick_resting();
      case ($urandom_range(0, 3))
        0: send(lobu_pkg::OP_EXECUTE, key, rand64(), instr, rand_side(),
                ($urandom_range(0, 4) == 0) ? pick_qty() : 32'($urandom_range(1, 60)),
                px, rand_stamp());
        1: send(lobu_pkg::OP_CANCEL, key, rand64(), instr, rand_side(),
                ($urandom_range(0, 4) == 0) ? pick_qty() : 32'($urandom_range(1, 60)),
                px, rand_stamp());
        2: begin
          send(lobu_pkg::OP_DELETE, key, rand64(), instr, rand_side(), pick_qty(), px,
               rand_stamp());
          forget_key(key);
        end
        default: begin
          // replace onto a resting key now and then
          nkey = ($urandom_range(0, 5) == 0) ? pick_resting() : rand64();
          send(lobu_pkg::OP_REPLACE, key, nkey, instr, rand_side(), pick_qty(), px,
               rand_stamp());
          forget_key(key);
          forget_key(nkey);
          remember_key(nkey);
        end
      endcase
    end else begin
      send(3'($urandom_range(5, 7)), rand64(), rand64(), instr, rand_side(),
           $urandom, $urandom, rand_stamp());
    end
  endtask

  // Receiver: ready follows a mode that is drawn anew at random spans,
  // and once, after some results, it holds off long enough for a result to
  // park in the output register and the input to stall behind it.
  initial begin
    int mode_left, mode, hold_left;
    logic hold_done;
    mode_left = 0; mode = 0; hold_left = 0; hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (book_out.valid && book_out.ready) results_seen++;
      if (!hold_done && results_seen == 40) begin
        hold_done = 1'b1;
        hold_left = 6000;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(200, 3000);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        book_out.ready <= 1'b0;
      end else begin
        case (mode)
          0:       book_out.ready <= 1'b1;
          1:       book_out.ready <= ($urandom_range(0, 1) == 1);
          default: book_out.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  initial begin
    logic [47:0] t_max;
    t_max = '1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: basic adds on both sides, extreme keys, prices and sizes
    send(lobu_pkg::OP_ADD, 64'd1, 64'd0, 4'd0, 1'b1, 32'd100, 32'd500, 48'd10);
    send(lobu_pkg::OP_ADD, 64'd2, 64'd0, 4'd0, 1'b0, 32'd50, 32'd600, 48'd11);
    send(lobu_pkg::OP_ADD, 64'd3, 64'd0, 4'd0, 1'b1, 32'd0, 32'd0, 48'd12);  // zero size, price
    send(lobu_pkg::OP_ADD, '1, '1, 4'd15, 1'b0, '1, '1, t_max);
    // duplicate add overwrites the slot, old shares stay at their level
    send(lobu_pkg::OP_ADD, 64'd1, 64'd0, 4'd0, 1'b1, 32'd30, 32'd510, 48'd13);
    send(lobu_pkg::OP_EXECUTE, 64'd2, 64'd0, 4'd0, 1'b0, 32'd20, 32'd0, 48'd14);
    send(lobu_pkg::OP_CANCEL, 64'd2, 64'd0, 4'd0, 1'b0, 32'd100, 32'd0, 48'd15);  // oversize
    send(lobu_pkg::OP_EXECUTE, 64'd3, 64'd0, 4'd0, 1'b1, 32'd0, 32'd0, 48'd16);   // zero-size
    send(lobu_pkg::OP_DELETE, '1, 64'd0, 4'd3, 1'b0, 32'd0, 32'd0, 48'd17);
    // unknown keys change nothing
    send(lobu_pkg::OP_DELETE, 64'd0, 64'd0, 4'd6, 1'b0, 32'd0, 32'd0, 48'd18);
    send(lobu_pkg::OP_EXECUTE, 64'd77, 64'd0, 4'd6, 1'b1, 32'd5, 32'd0, 48'd19);
    send(lobu_pkg::OP_CANCEL, 64'd78, 64'd0, 4'd6, 1'b1, 32'd5, 32'd0, 48'd20);
    send(lobu_pkg::OP_REPLACE, 64'd79, 64'd80, 4'd6, 1'b1, 32'd5, 32'd9, 48'd21);
    send(lobu_pkg::OP_ADD, 64'd5, 64'd0, 4'd7, 1'b0, 32'd10, 32'd700, 48'd22);
    send(lobu_pkg::OP_ADD, 64'd6, 64'd0, 4'd7, 1'b0, 32'd10, 32'd700, 48'd23);
    send(lobu_pkg::OP_REPLACE, 64'd5, 64'd7, 4'd0, 1'b1, 32'd40, 32'd650, 48'd24);
    send(lobu_pkg::OP_REPLACE, 64'd6, 64'd1, 4'd0, 1'b1, 32'd25, 32'd700, 48'd25);  // held key
    send(3'd5, 64'd7, 64'd0, 4'd7, 1'b0, 32'd1, 32'd1, 48'd26);
    send(3'd6, 64'd7, 64'd0, 4'd7, 1'b1, 32'd1, 32'd1, 48'd27);
    send(3'd7, '1, '1, '1, 1'b1, '1, '1, t_max);
    send(lobu_pkg::OP_ADD, 64'd0, 64'd0, 4'd9, 1'b1, 32'd0, 32'd0, t_max);
    resting_keys = '{64'd7, 64'd1, 64'd0};

    repeat (450) random_message(35);

    // fill one side of one book past its level capacity, then replace
    // with the freed-level allowance, then delete most of its orders
    for (int i = 0; i < lobu_pkg::LEVELS_PER_SIDE + 2; i++)
      send(lobu_pkg::OP_ADD, 64'h7000_0000 + i, 64'd0, 4'd5, 1'b1, 32'd3, 32'(2000 + i),
           rand_stamp());
    send(lobu_pkg::OP_REPLACE, 64'h7000_0000, 64'h7100_0000, 4'd5, 1'b1, 32'd4, 32'd9999,
         rand_stamp());
    send(lobu_pkg::OP_REPLACE, 64'h7000_0001, 64'h7100_0001, 4'd5, 1'b1, 32'd4, 32'd2002,
         rand_stamp());
    send(lobu_pkg::OP_ADD, 64'h7200_0000, 64'd0, 4'd5, 1'b1, 32'd1, 32'd1, rand_stamp());
    for (int i = 2; i < lobu_pkg::LEVELS_PER_SIDE; i++)
      if (i % 3 != 0)
        send(lobu_pkg::OP_DELETE, 64'h7000_0000 + i, 64'd0, 4'd5, 1'b1, 32'd0, 32'd0,
             rand_stamp());

    // fill the order table; the last adds must report a full table
    for (int i = 0; i < lobu_pkg::ORDER_SLOTS; i++) begin
      send(lobu_pkg::OP_ADD, 64'h5_0000_0000 + i, 64'd0, 4'(i), 1'(i >> 4), 32'(1 + i % 7),
           32'(300 + i % 5), rand_stamp());
      remember_key(64'h5_0000_0000 + i);
    end
    repeat (150) random_message(20);

    @(posedge clk);
    order_in.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (fail_count == 0) $display("limit_order_book_update: match");
    else $display("limit_order_book_update: mismatch");
    $finish;
  end

  // Roughly 1750 messages, each with its sweeps, plus the clearing pass,
  // taken several times over.
  initial begin
    #80ms;
    $display("limit_order_book_update: mismatch");
    $finish;
  end

endmodule
